>>> rtl/tsrf_pkg.sv
// Package for the time-sync request sequencer.
// Holds the phase type, register indexes, frame and reply constants and the digit helper.
// No dependencies.
package tsrf_pkg;

    localparam int STORE_BYTES_DEF = 32;

    // only the first bytes of the receive store are ever inspected
    localparam int REPLY_BYTES = 23;
    localparam int REPLY_IDX_W = 5;
    localparam int CLEAR_BYTES = 20;

    localparam int FRAME_BYTES = 9;
    localparam int FRAME_IDX_W = 4;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_DELAY  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_TIMEOUT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_READER_ID   = 2'd2;

    localparam logic [15:0] STEP_DELAY_RST  = 16'd10;
    localparam logic [15:0] ACK_TIMEOUT_RST = 16'd100;

    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_BYTE   = 2'd1;
    localparam logic [1:0] REQ_REWIND = 2'd2;
    localparam logic [1:0] REQ_ENABLE = 2'd3;

    localparam logic OUT_FRAME = 1'b0;
    localparam logic OUT_CLOCK = 1'b1;

    localparam logic [7:0] CH_LT   = 8'h3C; // '<'
    localparam logic [7:0] CH_F    = 8'h46; // 'F'
    localparam logic [7:0] CH_E    = 8'h45; // 'E'
    localparam logic [7:0] CH_SEMI = 8'h3B; // ';'
    localparam logic [7:0] CH_O    = 8'h4F; // 'O'
    localparam logic [7:0] CH_K    = 8'h4B; // 'K'
    localparam logic [7:0] CH_GT   = 8'h3E; // '>'
    localparam logic [7:0] CH_ZERO = 8'h30; // '0'
    localparam logic [7:0] TEN     = 8'd10;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_CHECK  = 3'd1,
        PH_SEND   = 3'd2,
        PH_WAIT   = 3'd3,
        PH_FINISH = 3'd4
    } phase_t;

    // two ASCII digits to a value, wrapping at 8 bits
    function automatic logic [7:0] two_digits(input logic [7:0] tens, input logic [7:0] units);
        logic [7:0] t;
        logic [7:0] u;
        t = tens - CH_ZERO;
        u = units - CH_ZERO;
        return 8'(t * TEN) + u;
    endfunction

endpackage

>>> rtl/time_sync_request_fsm.sv
// Time-sync request sequencer, top level.
// Depends on tsrf_pkg for the phase type, constants and the digit helper.
//
// Usage:
//   s_* channel carries one request per transaction: s_tuser is the request
//   type (tick, received byte, rewind receive pointer, enable), s_tdata the
//   received byte. m_* channel carries results: request frame bytes
//   (m_tuser 0, m_tlast on the closing '>') and the clock setting
//   (m_tuser 1, m_tlast 1) with the parsed date and time in m_tdata.
//   cfg_* writes step_delay, ack_timeout and reader_id; always ready.
// Latency and throughput:
//   Each request is processed in the cycle it is accepted; its first result
//   appears on m_* the next cycle. One request per cycle is taken while the
//   output register is empty or drains its final beat. A send step emits a
//   nine-byte frame from the output serializer, one byte per cycle while
//   m_tready is high, and the input holds off until its last byte is taken;
//   a clock setting is a single beat, and a new request is taken with it.
// Reset:
//   rst_n clears phase, counters, flags, receive store and held time, and
//   loads the register defaults.
// Stall:
//   While m_tready is low the pending result holds and s_tready stays low.
module time_sync_request_fsm
#(
    parameter int STORE_BYTES = tsrf_pkg::STORE_BYTES_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] rx_byte
    input  logic [1:0]                       s_tuser,   // [1:0] req_type

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] tx_byte, [15:8] second, [23:16] minute, [31:24] hour,
    // [39:32] day, [47:40] month, [55:48] year
    output logic [55:0]                      m_tdata,
    output logic                             m_tuser,   // [0] out_kind
    output logic                             m_tlast,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tsrf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tsrf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import tsrf_pkg::*;

    localparam int PTR_W = $clog2(STORE_BYTES + 1);

    // configuration
    logic [15:0] step_delay_reg;
    logic [15:0] ack_timeout_reg;
    logic [31:0] reader_id_reg;

    // sequencer state
    phase_t      phase_reg, phase_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic        enabled_reg, enabled_next;
    logic        synced_reg, synced_next;
    logic [PTR_W-1:0] rx_pointer_reg, rx_pointer_next;
    logic [7:0]  rx_store_reg [REPLY_BYTES];
    logic [7:0]  held_time_reg [6];

    // output serializer
    logic                   out_valid_reg;
    logic                   out_kind_reg;
    logic [FRAME_IDX_W-1:0] out_idx_reg;

    logic        accept;
    logic        out_fire;
    logic        out_last_beat;
    logic        emit_frame;
    logic        emit_clock;
    logic        store_write;
    logic        store_clear;
    logic        reply_ok;
    logic [15:0] tick_inc;
    logic        passed;
    logic [7:0]  frame_byte;

    assign cfg_ready = 1'b1;

    assign out_last_beat = (out_kind_reg == OUT_CLOCK) ||
                           (out_idx_reg == FRAME_IDX_W'(FRAME_BYTES - 1));
    assign out_fire      = out_valid_reg && m_tready;
    assign s_tready      = !out_valid_reg || (m_tready && out_last_beat);
    assign accept        = s_tvalid && s_tready;

    assign tick_inc = tick_count_reg + 16'd1;
    assign passed   = tick_inc > step_delay_reg;

    assign reply_ok = (rx_store_reg[0] == CH_LT)   && (rx_store_reg[1] == CH_F) &&
                      (rx_store_reg[2] == CH_E)    && (rx_store_reg[3] == CH_SEMI) &&
                      (rx_store_reg[4] == CH_O)    && (rx_store_reg[5] == CH_K) &&
                      (rx_store_reg[6] == CH_SEMI) && (rx_store_reg[15] == CH_SEMI) &&
                      (rx_store_reg[22] == CH_GT);

    // next state of the sequencer
    always_comb
    begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        enabled_next    = enabled_reg;
        synced_next     = synced_reg;
        rx_pointer_next = rx_pointer_reg;
        emit_frame      = 1'b0;
        emit_clock      = 1'b0;
        store_write     = 1'b0;
        store_clear     = 1'b0;
        if (accept)
        begin
            unique case (s_tuser)
                REQ_TICK:
                begin
                    tick_count_next = tick_inc;
                    unique case (phase_reg)
                        PH_IDLE:
                        begin
                            if (passed)
                            begin
                                tick_count_next = '0;
                                if (enabled_reg)
                                    phase_next = PH_CHECK;
                            end
                        end
                        PH_CHECK:
                        begin
                            if (passed)
                            begin
                                tick_count_next = '0;
                                if (enabled_reg && !synced_reg)
                                    phase_next = PH_SEND;
                            end
                        end
                        PH_SEND:
                        begin
                            if (passed)
                            begin
                                tick_count_next = '0;
                                if (enabled_reg)
                                begin
                                    emit_frame = 1'b1;
                                    phase_next = PH_WAIT;
                                end
                            end
                        end
                        PH_WAIT:
                        begin
                            if (tick_inc < ack_timeout_reg)
                            begin
                                if (enabled_reg && reply_ok)
                                begin
                                    store_clear = 1'b1;
                                    phase_next  = PH_FINISH;
                                end
                            end
                            else
                            begin
                                tick_count_next = '0;
                                phase_next      = PH_SEND;
                            end
                        end
                        PH_FINISH:
                        begin
                            if (passed && enabled_reg)
                            begin
                                tick_count_next = '0;
                                synced_next     = 1'b1;
                                enabled_next    = 1'b0;
                                emit_clock      = 1'b1;
                                phase_next      = PH_IDLE;
                            end
                        end
                        default:
                        begin
                            // unused phase codes only advance the counter
                        end
                    endcase
                end
                REQ_BYTE:
                begin
                    // saturate at the end of the store
                    if (rx_pointer_reg < PTR_W'(STORE_BYTES))
                    begin
                        rx_pointer_next = rx_pointer_reg + PTR_W'(1);
                        store_write     = rx_pointer_reg < PTR_W'(REPLY_BYTES);
                    end
                end
                REQ_REWIND:
                begin
                    rx_pointer_next = '0;
                end
                REQ_ENABLE:
                begin
                    enabled_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_delay_reg  <= STEP_DELAY_RST;
            ack_timeout_reg <= ACK_TIMEOUT_RST;
            reader_id_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_STEP_DELAY:  step_delay_reg  <= cfg_data[15:0];
                CFG_ACK_TIMEOUT: ack_timeout_reg <= cfg_data[15:0];
                CFG_READER_ID:   reader_id_reg   <= cfg_data;
                default:
                begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= '0;
            enabled_reg    <= 1'b0;
            synced_reg     <= 1'b0;
            rx_pointer_reg <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            enabled_reg    <= enabled_next;
            synced_reg     <= synced_next;
            rx_pointer_reg <= rx_pointer_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REPLY_BYTES; i++)
                rx_store_reg[i] <= '0;
        end
        else if (store_write)
        begin
            rx_store_reg[rx_pointer_reg[REPLY_IDX_W-1:0]] <= s_tdata;
        end
        else if (store_clear)
        begin
            for (int i = 0; i < CLEAR_BYTES; i++)
                rx_store_reg[i] <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                held_time_reg[i] <= '0;
        end
        else if (store_clear)
        begin
            held_time_reg[3] <= two_digits(rx_store_reg[7],  rx_store_reg[8]);
            held_time_reg[4] <= two_digits(rx_store_reg[9],  rx_store_reg[10]);
            held_time_reg[5] <= two_digits(rx_store_reg[13], rx_store_reg[14]);
            held_time_reg[2] <= two_digits(rx_store_reg[16], rx_store_reg[17]);
            held_time_reg[1] <= two_digits(rx_store_reg[18], rx_store_reg[19]);
            held_time_reg[0] <= two_digits(rx_store_reg[20], rx_store_reg[21]);
        end
    end

    // output serializer: load on a new result, advance one beat per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_kind_reg  <= OUT_FRAME;
            out_idx_reg   <= '0;
        end
        else if (emit_frame || emit_clock)
        begin
            out_valid_reg <= 1'b1;
            out_kind_reg  <= emit_clock ? OUT_CLOCK : OUT_FRAME;
            out_idx_reg   <= '0;
        end
        else if (out_fire)
        begin
            if (out_last_beat)
                out_valid_reg <= 1'b0;
            else
                out_idx_reg <= out_idx_reg + FRAME_IDX_W'(1);
        end
    end

    always_comb
    begin
        unique case (out_idx_reg)
            4'd0:    frame_byte = CH_LT;
            4'd1:    frame_byte = CH_F;
            4'd2:    frame_byte = CH_E;
            4'd3:    frame_byte = CH_SEMI;
            4'd4:    frame_byte = reader_id_reg[31:24];
            4'd5:    frame_byte = reader_id_reg[23:16];
            4'd6:    frame_byte = reader_id_reg[15:8];
            4'd7:    frame_byte = reader_id_reg[7:0];
            default: frame_byte = CH_GT;
        endcase
    end

    // result fields
    always_comb
    begin
        m_tvalid = out_valid_reg;
        m_tuser  = out_kind_reg;
        m_tlast  = out_last_beat;
        if (out_kind_reg == OUT_CLOCK)
            m_tdata = {held_time_reg[5], held_time_reg[4], held_time_reg[3],
                       held_time_reg[2], held_time_reg[1], held_time_reg[0], 8'd0};
        else
            m_tdata = {48'd0, frame_byte};
    end

endmodule
